[design/hsis_pkg.sv]
// Shared types, constants and tanh table functions for the haptic sample scaler.
package hsis_pkg;

  localparam int SAMPLE_BITS      = 20;
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int FRAC_BITS        = 16;
  localparam int GAIN_BITS        = 16;
  localparam int MODE_BITS        = 3;
  localparam int CFG_IDX_BITS     = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_MODE      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_FACTOR     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TANH_NORM       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATIONAL_CLAMP  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOUNDS_FIX      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ADAPTIVE_ENABLE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ADAPTIVE_GAIN   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LIMIT      = 3'd7;

  // curve_mode codes
  localparam logic [MODE_BITS-1:0] MODE_MUTE     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_BYPASS   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_RATIONAL = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_LINEAR   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_TANH     = 3'd4;

  localparam logic [GAIN_BITS-1:0] GAIN_UNIT = 16'd4096;

  typedef enum logic [2:0] {
    KIND_MUTE,
    KIND_BYPASS,
    KIND_RATIONAL,
    KIND_LINEAR,
    KIND_TANH
  } curve_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;
    logic                          end_of_buffer_out;
  } out_beat_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]          curve_mode;
    logic [GAIN_BITS-1:0]          gain_factor;
    logic [GAIN_BITS-1:0]          tanh_norm;
    logic                          rational_clamp;
    logic                          bounds_fix;
    logic                          adaptive_enable;
    logic [GAIN_BITS-1:0]          adaptive_gain;
    logic signed [SAMPLE_BITS-1:0] clip_limit;
  } cfg_t;

  // Classified sample as it travels from front to back
  typedef struct packed {
    curve_e                 kind;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   eob;
  } job_t;

  // Unsigned quotient by shift and subtract; elaboration-time only
  function automatic longint unsigned const_quo(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    begin
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        r = {r[62:0], n[b]};
        if (r >= d) begin
          r    = r - d;
          q[b] = 1'b1;
        end
      end
      return q;
    end
  endfunction

  // tanh(8*z) in Q.16 with z in Q.30; elaboration-time only
  function automatic longint unsigned tanh_point(longint unsigned z);
    longint unsigned e;
    longint unsigned term;
    longint unsigned r;
    longint unsigned den;
    longint unsigned one;
    begin
      one  = 64'd1 << 30;
      e    = one;
      term = one;
      for (int k = 1; k <= 24; k++) begin
        term = const_quo((term * z) >> 30, longint'(k));
        e    = e + term;
      end
      r = const_quo(one << 30, e);
      for (int s = 0; s < 4; s++) begin
        r = (r * r + (one >> 1)) >> 30;
      end
      den = one + r;
      return const_quo(((one - r) << FRAC_BITS) + (den >> 1), den);
    end
  endfunction

endpackage

[design/hsis_front.sv]
// Front end: accept sample commands and classify them into jobs.
module hsis_front import hsis_pkg::*; (
  input  logic     start_i,
  input  logic     full_i,
  input  in_beat_t in_i,
  input  cfg_t     cfg_i,
  output logic     push_o,
  output job_t     job_o
);

  logic [SAMPLE_BITS-1:0] raw;

  assign raw    = in_i.sample_in;
  assign push_o = start_i && !full_i;

  always_comb begin
    job_o.neg = raw[SAMPLE_BITS-1];
    job_o.mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    job_o.eob = in_i.end_of_buffer;
    unique case (cfg_i.curve_mode)
      MODE_MUTE:     job_o.kind = KIND_MUTE;
      MODE_RATIONAL: job_o.kind = KIND_RATIONAL;
      MODE_LINEAR:   job_o.kind = KIND_LINEAR;
      MODE_TANH:     job_o.kind = KIND_TANH;
      default:       job_o.kind = KIND_BYPASS;
    endcase
  end

endmodule

[design/hsis_fifo.sv]
// Two-entry job queue between front and back.
module hsis_fifo import hsis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);

  job_t              mem_q [QDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

[design/hsis_back.sv]
// Back end: curve, adaptive gain, clip and saturation pipeline.
module hsis_back import hsis_pkg::*; #(
  parameter int TanhDepth = TANH_TABLE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      done_o,
  output out_beat_t out_o
);

  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = SB + GAIN_BITS;
  localparam int MMW  = 2 * SB;
  localparam int LW   = PW - 11;
  localparam int XW   = PW - 12;
  localparam int DW   = MMW - 11;
  localparam int NW   = PW + 5;
  localparam int AW   = LW + 5;
  localparam int TW   = FRAC_BITS + 1;
  localparam int SPB  = FRAC_BITS + 3;
  localparam int IW   = $clog2(TanhDepth + 1);
  localparam int PRW  = XW + IW + 1;
  localparam int IPW  = TW + SPB;
  localparam int YAW  = TW + GAIN_BITS;
  localparam int AMW  = LW + GAIN_BITS;
  localparam int LAT  = NW + 9;

  localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

  typedef struct packed {
    job_t            job;
    logic            use_lin;
    logic [LW-1:0]   lin;
  } ctx_t;

  typedef logic [TanhDepth:0][TW-1:0] tab_t;

  // Monotone tanh table over arguments 0..8, running maximum of the points
  function automatic tab_t build_tanh_tab();
    tab_t            tab;
    longint unsigned t;
    longint unsigned best;
    begin
      best = 0;
      for (int i = 0; i <= TanhDepth; i++) begin
        t = tanh_point(const_quo(longint'(i) << 30, longint'(TanhDepth)));
        if (t > best) begin
          best = t;
        end
        tab[i] = best[TW-1:0];
      end
      return tab;
    end
  endfunction

  localparam tab_t TANH_TAB = build_tanh_tab();

  // stage 1: products
  logic           s1_v_q;
  job_t           s1_job_q;
  logic [PW-1:0]  s1_p_q;
  logic [MMW-1:0] s1_mm_q;

  // stage 2: rounding, denominator product
  logic           s2_v_q;
  job_t           s2_job_q;
  logic [PW-1:0]  s2_p_q;
  logic [LW-1:0]  s2_lin_q;
  logic [XW-1:0]  s2_x_q;
  logic [MMW-1:0] s2_dq_q;
  logic [PW:0]    s2_sum_lin, s2_sum_x;

  // stage 3..7 common
  logic           sc_v_q   [3:7];
  ctx_t           sc_ctx_q [3:7];
  logic [NW-1:0]  sc_num_q [3:7];
  logic [DW-1:0]  sc_d_q   [3:7];

  // tanh specific
  logic [TW-1:0]  s3_lo_q, s3_hi_q, s4_lo_q;
  logic [SPB-1:0] s3_fr_q;
  logic           s3_xs_q, s4_xs_q;
  logic [IPW-1:0] s4_ip_q;
  logic [TW-1:0]  s5_t_q;
  logic [YAW-1:0] s6_ya_q;
  logic [TW-1:0]  s7_ty_q;

  logic           s3_xs;
  logic [PRW-1:0] s3_xd;
  logic [IW-1:0]  s3_idx, s3_idx1;
  logic [DW-1:0]  s3_d;
  logic [IPW:0]   s5_sum;
  logic [YAW:0]   s7_sum;
  logic [YAW-1-12+1:0] s7_raw;

  assign s2_sum_lin = {1'b0, s1_p_q} + (PW+1)'(2048);
  assign s2_sum_x   = {1'b0, s1_p_q} + (PW+1)'(4096);

  assign s3_xs   = (s2_x_q[XW-1:SPB] != '0);
  assign s3_xd   = PRW'(s2_x_q) * PRW'(TanhDepth);
  assign s3_idx  = s3_xs ? '0 : s3_xd[SPB+IW-1:SPB];
  assign s3_idx1 = s3_idx + 1'b1;
  assign s3_d    = DW'(65536) + DW'(s2_dq_q[MMW-1:12]);

  assign s5_sum  = {1'b0, s4_ip_q} + (IPW+1)'(1 << (SPB-1));
  assign s7_sum  = {1'b0, s6_ya_q} + (YAW+1)'(2048);
  assign s7_raw  = s7_sum[YAW:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      for (int i = 3; i <= 7; i++) begin
        sc_v_q[i] <= 1'b0;
      end
    end else begin
      s1_v_q    <= job_valid_i;
      s2_v_q    <= s1_v_q;
      sc_v_q[3] <= s2_v_q;
      for (int i = 4; i <= 7; i++) begin
        sc_v_q[i] <= sc_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_job_q <= job_i;
    s1_p_q   <= PW'(job_i.mag) * PW'(cfg_i.gain_factor);
    s1_mm_q  <= MMW'(job_i.mag) * MMW'(job_i.mag);

    s2_job_q <= s1_job_q;
    s2_p_q   <= s1_p_q;
    s2_lin_q <= s2_sum_lin[PW:12];
    s2_x_q   <= s2_sum_x[PW:13];
    s2_dq_q  <= MMW'(cfg_i.gain_factor - GAIN_UNIT) * MMW'(s1_mm_q[MMW-1:16]);

    sc_ctx_q[3].job     <= s2_job_q;
    sc_ctx_q[3].lin     <= s2_lin_q;
    sc_ctx_q[3].use_lin <= (cfg_i.gain_factor <= GAIN_UNIT) || (s2_job_q.mag == '0);
    sc_num_q[3]         <= NW'({s2_p_q, 4'b0000}) + NW'(s3_d >> 1);
    sc_d_q[3]           <= s3_d;
    s3_lo_q             <= TANH_TAB[s3_idx];
    s3_hi_q             <= TANH_TAB[s3_idx1];
    s3_fr_q             <= s3_xd[SPB-1:0];
    s3_xs_q             <= s3_xs;
    for (int i = 4; i <= 7; i++) begin
      sc_ctx_q[i] <= sc_ctx_q[i-1];
      sc_num_q[i] <= sc_num_q[i-1];
      sc_d_q[i]   <= sc_d_q[i-1];
    end

    s4_ip_q <= IPW'(s3_hi_q - s3_lo_q) * IPW'(s3_fr_q);
    s4_lo_q <= s3_lo_q;
    s4_xs_q <= s3_xs_q;
    s5_t_q  <= s4_xs_q ? ONE_T : s4_lo_q + TW'(s5_sum[IPW:SPB]);
    s6_ya_q <= YAW'(s5_t_q) * YAW'(cfg_i.tanh_norm);
    s7_ty_q <= (s7_raw > ($bits(s7_raw))'(ONE_T)) ? ONE_T : TW'(s7_raw);
  end

  // restoring divider, one quotient bit per stage
  logic          dv_v_q   [NW];
  ctx_t          dv_ctx_q [NW];
  logic [TW-1:0] dv_ty_q  [NW];
  logic [DW-1:0] dv_rem_q [NW];
  logic [NW-1:0] dv_num_q [NW];
  logic [NW-1:0] dv_quo_q [NW];
  logic [DW-1:0] dv_d_q   [NW];

  for (genvar gs = 0; gs < NW; gs++) begin : g_div
    logic          v_in;
    ctx_t          ctx_in;
    logic [TW-1:0] ty_in;
    logic [DW-1:0] rem_in, d_in, rem_out;
    logic [NW-1:0] num_in, quo_in;
    logic [DW:0]   trial;
    logic          qbit;

    if (gs == 0) begin : g_first
      assign v_in   = sc_v_q[7];
      assign ctx_in = sc_ctx_q[7];
      assign ty_in  = s7_ty_q;
      assign rem_in = '0;
      assign num_in = sc_num_q[7];
      assign quo_in = '0;
      assign d_in   = sc_d_q[7];
    end else begin : g_rest
      assign v_in   = dv_v_q[gs-1];
      assign ctx_in = dv_ctx_q[gs-1];
      assign ty_in  = dv_ty_q[gs-1];
      assign rem_in = dv_rem_q[gs-1];
      assign num_in = dv_num_q[gs-1];
      assign quo_in = dv_quo_q[gs-1];
      assign d_in   = dv_d_q[gs-1];
    end

    always_comb begin
      trial   = {rem_in, num_in[NW-1]};
      qbit    = (trial >= {1'b0, d_in});
      rem_out = qbit ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[gs] <= 1'b0;
      end else begin
        dv_v_q[gs] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_ctx_q[gs] <= ctx_in;
      dv_ty_q[gs]  <= ty_in;
      dv_rem_q[gs] <= rem_out;
      dv_num_q[gs] <= num_in << 1;
      dv_quo_q[gs] <= {quo_in[NW-2:0], qbit};
      dv_d_q[gs]   <= d_in;
    end
  end

  // post stage A: curve select and adaptive product
  ctx_t          fin_ctx;
  logic [LW-1:0] pa_ysel, pa_rat;
  logic          pa_scaled;
  logic          pa_v_q, pa_adapt_q, pa_neg_q, pa_eob_q;
  logic [LW-1:0] pa_y_q;
  logic [AMW-1:0] pa_am_q;

  assign fin_ctx = dv_ctx_q[NW-1];

  always_comb begin
    pa_rat = fin_ctx.use_lin ? fin_ctx.lin : dv_quo_q[NW-1][LW-1:0];
    if (cfg_i.rational_clamp && (pa_rat > LW'(ONE_T))) begin
      pa_rat = LW'(ONE_T);
    end
    pa_scaled = 1'b1;
    unique case (fin_ctx.job.kind)
      KIND_MUTE: begin
        pa_ysel   = '0;
        pa_scaled = 1'b0;
      end
      KIND_RATIONAL: pa_ysel = pa_rat;
      KIND_LINEAR:   pa_ysel = fin_ctx.lin;
      KIND_TANH:     pa_ysel = LW'(dv_ty_q[NW-1]);
      default: begin
        pa_ysel   = LW'(fin_ctx.job.mag);
        pa_scaled = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_v_q <= 1'b0;
    end else begin
      pa_v_q <= dv_v_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pa_y_q     <= pa_ysel;
    pa_am_q    <= AMW'(pa_ysel) * AMW'(cfg_i.adaptive_gain);
    pa_adapt_q <= pa_scaled && cfg_i.adaptive_enable && (cfg_i.adaptive_gain != GAIN_UNIT);
    pa_neg_q   <= fin_ctx.job.neg;
    pa_eob_q   <= fin_ctx.job.eob;
  end

  // post stage B: adaptive rounding, clip, saturate
  logic [AMW:0]   pb_sum;
  logic [AW-1:0]  pb_v;
  logic           pb_lneg;
  logic [SB-1:0]  pb_lmag, pb_lim, pb_mag;
  logic           pb_sat;
  out_beat_t      pb_out;

  assign pb_sum  = {1'b0, pa_am_q} + (AMW+1)'(2048);
  assign pb_lneg = cfg_i.clip_limit[SB-1];
  assign pb_lmag = pb_lneg ? (~cfg_i.clip_limit + 1'b1) : cfg_i.clip_limit;

  always_comb begin
    if (pa_adapt_q) begin
      pb_v = pb_sum[AMW:12];
      if (cfg_i.bounds_fix && (pb_v > AW'(ONE_T))) begin
        pb_v = AW'(ONE_T);
      end
    end else begin
      pb_v = AW'(pa_y_q);
    end
    // clip: open interval with bounds_fix, magnitude otherwise
    if (cfg_i.bounds_fix) begin
      if (!pb_lneg && (pb_lmag != '0) && (AW'(pb_lmag) < AW'(ONE_T)) &&
          (pb_v > AW'(pb_lmag))) begin
        pb_v = AW'(pb_lmag);
      end
    end else if ((pb_lmag != '0) && (pb_v > AW'(pb_lmag))) begin
      pb_v = AW'(pb_lmag);
    end
    pb_lim = pa_neg_q ? (SB'(1) << (SB-1)) : ((SB'(1) << (SB-1)) - 1'b1);
    pb_sat = (pb_v > AW'(pb_lim));
    pb_mag = pb_sat ? pb_lim : pb_v[SB-1:0];
    pb_out.sample_out        = (pa_neg_q && (pb_mag != '0)) ? (~pb_mag + 1'b1) : pb_mag;
    pb_out.saturated         = pb_sat;
    pb_out.end_of_buffer_out = pa_eob_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= pa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_o <= pb_out;
  end

  logic [SB-1:0] out_mag;
  assign out_mag = out_o.sample_out[SB-1] ? (~out_o.sample_out + 1'b1) : out_o.sample_out;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(job_valid_i, LAT))
    else $error("result beat without a job at the pipeline entry");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.saturated) |->
      (out_o.sample_out == {1'b0, {(SB-1){1'b1}}} ||
       out_o.sample_out == {1'b1, {(SB-1){1'b0}}}))
    else $error("saturated beat is not at a range end");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cfg_i.bounds_fix && !cfg_i.clip_limit[SB-1] &&
     cfg_i.clip_limit != '0 && cfg_i.clip_limit < SB'(ONE_T) &&
     $stable(cfg_i)) |-> (out_mag <= cfg_i.clip_limit))
    else $error("clipped beat exceeds the clip limit");

endmodule

[design/haptic_sample_intensity_scaler.sv]
// Top level of the haptic sample intensity scaler.
//
// Usage:
//   Command channel: drive start with a sample beat on in_i; the beat is
//   taken at a rising edge where start is high and busy is low. One
//   beat can be taken every cycle.
//   Result channel: done_o strobes for one cycle with the result on out_o.
//   The receiver must take it in that cycle; there is no back-pressure.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
//   cfg_ready_o is always high. Write only while no sample is in flight.
// Pipeline: the rational curve's divider, one quotient bit per stage, makes up
//   most of the back end; tanh lookup and products fill the rest.
// Throughput: one sample per cycle; the back pipeline never stalls, so the
//   two-entry queue between front and back never fills and busy stays low.
// Reset: rst_ni clears all pipeline valids and loads the register defaults
//   (bypass curve, unity gains, clamps on, adaptive gain off, no clip).
module haptic_sample_intensity_scaler import hsis_pkg::*; #(
  parameter int TanhTableDepth = TANH_TABLE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  in_beat_t                in_i,
  output logic                    done_o,
  output out_beat_t               out_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]  cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic push, full, job_valid;
  job_t front_job, back_job;

  assign cfg_ready_o = 1'b1;
  assign busy        = full;

  // register writes, truncated to each register's width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CURVE_MODE:      cfg_d.curve_mode      = cfg_data_i[MODE_BITS-1:0];
        CFG_GAIN_FACTOR:     cfg_d.gain_factor     = cfg_data_i[GAIN_BITS-1:0];
        CFG_TANH_NORM:       cfg_d.tanh_norm       = cfg_data_i[GAIN_BITS-1:0];
        CFG_RATIONAL_CLAMP:  cfg_d.rational_clamp  = cfg_data_i[0];
        CFG_BOUNDS_FIX:      cfg_d.bounds_fix      = cfg_data_i[0];
        CFG_ADAPTIVE_ENABLE: cfg_d.adaptive_enable = cfg_data_i[0];
        CFG_ADAPTIVE_GAIN:   cfg_d.adaptive_gain   = cfg_data_i[GAIN_BITS-1:0];
        CFG_CLIP_LIMIT:      cfg_d.clip_limit      = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.curve_mode      <= MODE_BYPASS;
      cfg_q.gain_factor     <= GAIN_UNIT;
      cfg_q.tanh_norm       <= GAIN_UNIT;
      cfg_q.rational_clamp  <= 1'b1;
      cfg_q.bounds_fix      <= 1'b1;
      cfg_q.adaptive_enable <= 1'b0;
      cfg_q.adaptive_gain   <= GAIN_UNIT;
      cfg_q.clip_limit      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify the command beat
  hsis_front u_front (
    .start_i (start),
    .full_i  (full),
    .in_i    (in_i),
    .cfg_i   (cfg_q),
    .push_o  (push),
    .job_o   (front_job)
  );

  // decouple front from back
  hsis_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (1'b1),
    .full_o  (full),
    .valid_o (job_valid),
    .job_o   (back_job)
  );

  hsis_back #(
    .TanhDepth (TanhTableDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (back_job),
    .done_o      (done_o),
    .out_o       (out_o)
  );

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("job queue filled although the back end drains every cycle");

endmodule

[test/testbench.sv]
// Self-checking testbench for the haptic sample intensity scaler.
module testbench;
  import hsis_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam longint unsigned ONE_Q16 = 64'd1 << FRAC_BITS;
  localparam longint unsigned TANH_END = 64'd8 << FRAC_BITS;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  in_beat_t                in_i;
  logic                    done_o;
  out_beat_t               out_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [SAMPLE_BITS-1:0]  cfg_data_i;

  // Shadow copy of the register file and the tanh lookup it relies on
  cfg_t            shadow_cfg;
  longint unsigned tanh_lut[TANH_TABLE_DEPTH+1];
  out_beat_t       pending_outs[$];
  int              mismatch_count;
  int              cycle_count;

  haptic_sample_intensity_scaler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // tanh(8*z), z in Q.30 over [0,1], result in Q.16: series exp, then square up
  function automatic longint unsigned tanh_q16(longint unsigned z);
    longint unsigned unit_q30;
    longint unsigned acc;
    longint unsigned term;
    longint unsigned ex;
    longint unsigned den;
    unit_q30 = 64'd1 << 30;
    acc = unit_q30;
    term = unit_q30;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * z) >> 30) / longint'(n);
      acc += term;
    end
    ex = (unit_q30 << 30) / acc;
    for (int n = 0; n < 4; n++) ex = (ex * ex + (unit_q30 >> 1)) >> 30;
    den = unit_q30 + ex;
    return (((unit_q30 - ex) << FRAC_BITS) + den / 2) / den;
  endfunction

  // Fill the lookup, forcing it to be monotone
  task automatic fill_tanh_lut();
    longint unsigned pt;
    for (int n = 0; n <= TANH_TABLE_DEPTH; n++) begin
      pt = tanh_q16((longint'(n) << 30) / TANH_TABLE_DEPTH);
      if (n > 0 && pt < tanh_lut[n-1]) pt = tanh_lut[n-1];
      tanh_lut[n] = pt;
    end
  endtask

  function automatic longint unsigned apply_gain(longint unsigned m, longint unsigned g);
    return (m * g + 2048) >> 12;
  endfunction

  // Expected result for one sample beat under the shadow registers
  function automatic out_beat_t scale_sample(in_beat_t beat);
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] lim_raw;
    longint unsigned        span;
    longint unsigned        half;
    longint unsigned        m;
    longint unsigned        lmag;
    longint unsigned        s;
    longint unsigned        d;
    longint unsigned        x;
    longint unsigned        p;
    longint unsigned        idx;
    longint unsigned        fr;
    longint unsigned        t;
    longint unsigned        cap;
    logic                   neg;
    logic                   lneg;
    logic                   shaped;
    out_beat_t              res;
    span = 64'd1 << SAMPLE_BITS;
    half = 64'd1 << (SAMPLE_BITS - 1);
    raw = beat.sample_in;
    lim_raw = shadow_cfg.clip_limit;
    neg = raw[SAMPLE_BITS-1];
    m = neg ? span - raw : raw;
    lneg = lim_raw[SAMPLE_BITS-1];
    lmag = lneg ? span - lim_raw : lim_raw;
    s = shadow_cfg.gain_factor;
    shaped = 1'b1;
    case (shadow_cfg.curve_mode)
      MODE_MUTE: begin
        m = 0;
        shaped = 1'b0;
      end
      MODE_RATIONAL: begin
        if (s <= GAIN_UNIT || m == 0) begin
          m = apply_gain(m, s);
        end else begin
          d = ONE_Q16 + (((s - GAIN_UNIT) * ((m * m) >> FRAC_BITS)) >> 12);
          m = (((m * s) << 4) + d / 2) / d;
        end
        if (shadow_cfg.rational_clamp && m > ONE_Q16) m = ONE_Q16;
      end
      MODE_LINEAR: m = apply_gain(m, s);
      MODE_TANH: begin
        x = (m * s + 4096) >> 13;
        if (x >= TANH_END) begin
          t = ONE_Q16;
        end else begin
          p = x * TANH_TABLE_DEPTH;
          idx = p / TANH_END;
          fr = p % TANH_END;
          t = tanh_lut[idx] + ((tanh_lut[idx+1] - tanh_lut[idx]) * fr + TANH_END / 2)
              / TANH_END;
        end
        m = apply_gain(t, shadow_cfg.tanh_norm);
        if (m > ONE_Q16) m = ONE_Q16;
      end
      default: shaped = 1'b0;
    endcase
    if (shaped && shadow_cfg.adaptive_enable && shadow_cfg.adaptive_gain != GAIN_UNIT) begin
      m = apply_gain(m, shadow_cfg.adaptive_gain);
      if (shadow_cfg.bounds_fix && m > ONE_Q16) m = ONE_Q16;
    end
    // Open-interval positive limit with bounds fix, any nonzero magnitude without
    if (shadow_cfg.bounds_fix) begin
      if (!lneg && lmag != 0 && lmag < ONE_Q16 && m > lmag) m = lmag;
    end else if (lmag != 0 && m > lmag) begin
      m = lmag;
    end
    cap = neg ? half : half - 1;
    res.saturated = 1'b0;
    if (m > cap) begin
      m = cap;
      res.saturated = 1'b1;
    end
    if (m == 0) neg = 1'b0;
    res.sample_out = neg ? SAMPLE_BITS'(span - m) : SAMPLE_BITS'(m);
    res.end_of_buffer_out = beat.end_of_buffer;
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0d] %s: got %0h, want %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Check every strobed result against the oldest waiting prediction
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && done_o) begin
      if (pending_outs.size() == 0) begin
        report("unexpected result", 32'(out_o), 32'd0);
      end else begin
        want = pending_outs.pop_front();
        if (out_o.sample_out !== want.sample_out)
          report("sample_out", 32'(out_o.sample_out), 32'(want.sample_out));
        if (out_o.saturated !== want.saturated)
          report("saturated", 32'(out_o.saturated), 32'(want.saturated));
        if (out_o.end_of_buffer_out !== want.end_of_buffer_out)
          report("end_of_buffer_out", 32'(out_o.end_of_buffer_out),
                 32'(want.end_of_buffer_out));
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, and runs of back-to-back beats
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one sample beat; hold start high unless a gap follows
  task automatic send_sample(logic [SAMPLE_BITS-1:0] value, logic eob, int gap);
    in_beat_t beat;
    beat.sample_in = value;
    beat.end_of_buffer = eob;
    start <= 1'b1;
    in_i <= beat;
    do @(posedge clk_i); while (busy);
    pending_outs.push_back(scale_sample(beat));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait for all results, then let the pipeline go quiet before a register write
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_outs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SAMPLE_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Load a full register set, one beat per register
  task automatic load_cfg(cfg_t c);
    drain();
    write_reg(CFG_CURVE_MODE, SAMPLE_BITS'(c.curve_mode));
    write_reg(CFG_GAIN_FACTOR, SAMPLE_BITS'(c.gain_factor));
    write_reg(CFG_TANH_NORM, SAMPLE_BITS'(c.tanh_norm));
    write_reg(CFG_RATIONAL_CLAMP, SAMPLE_BITS'(c.rational_clamp));
    write_reg(CFG_BOUNDS_FIX, SAMPLE_BITS'(c.bounds_fix));
    write_reg(CFG_ADAPTIVE_ENABLE, SAMPLE_BITS'(c.adaptive_enable));
    write_reg(CFG_ADAPTIVE_GAIN, SAMPLE_BITS'(c.adaptive_gain));
    write_reg(CFG_CLIP_LIMIT, c.clip_limit);
    cfg_valid_i <= 1'b0;
    shadow_cfg = c;
  endtask

  function automatic cfg_t reset_cfg();
    cfg_t c;
    c.curve_mode = MODE_BYPASS;
    c.gain_factor = GAIN_UNIT;
    c.tanh_norm = GAIN_UNIT;
    c.rational_clamp = 1'b1;
    c.bounds_fix = 1'b1;
    c.adaptive_enable = 1'b0;
    c.adaptive_gain = GAIN_UNIT;
    c.clip_limit = '0;
    return c;
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return GAIN_UNIT;
      3: return GAIN_BITS'($urandom_range(2048, 12000));
      4: return GAIN_BITS'($urandom_range(0, 8192));
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_limit();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return SAMPLE_BITS'($urandom_range(1, 65535));
      2: return SAMPLE_BITS'(ONE_Q16);
      3: return SAMPLE_BITS'(-$signed(SAMPLE_BITS'($urandom_range(1, 65536))));
      4: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      5: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.curve_mode = MODE_BITS'($urandom_range(0, 7));
    // Favor the shaping curves, which carry most of the arithmetic
    if ($urandom_range(0, 3) != 0) c.curve_mode = MODE_BITS'($urandom_range(2, 4));
    c.gain_factor = pick_gain();
    c.tanh_norm = pick_gain();
    c.rational_clamp = 1'($urandom);
    c.bounds_fix = 1'($urandom);
    c.adaptive_enable = 1'($urandom);
    c.adaptive_gain = pick_gain();
    c.clip_limit = pick_limit();
    return c;
  endfunction

  // Nominal samples within about one and a half, some anywhere in range
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    if ($urandom_range(0, 3) == 0) return SAMPLE_BITS'($urandom);
    return SAMPLE_BITS'($urandom_range(0, 196608) - 98304);
  endfunction

  // Field extremes and the unit points, under the current registers
  task automatic send_edge_samples();
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}}, 1'b0, 0);
    send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}}, 1'b1, 0);
    send_sample('0, 1'b0, 1);
    send_sample(SAMPLE_BITS'(1), 1'b1, 0);
    send_sample('1, 1'b0, 0);
    send_sample(SAMPLE_BITS'(ONE_Q16), 1'b0, 2);
    send_sample(SAMPLE_BITS'(-ONE_Q16), 1'b1, 0);
    send_sample(SAMPLE_BITS'(32768), 1'b0, 0);
  endtask

  // Reset defaults: bypass, no clip
  task automatic test_reset_defaults();
    send_edge_samples();
  endtask

  // Every curve once, bounds fix on in the odd modes, a clip of 50000 but -40000 for linear, then an unused mode
  task automatic test_each_curve();
    cfg_t c;
    c = reset_cfg();
    c.gain_factor = 16'd12288;
    c.tanh_norm = 16'd4300;
    c.rational_clamp = 1'b0;
    c.adaptive_enable = 1'b1;
    c.adaptive_gain = 16'd6144;
    for (int mode = 0; mode <= 4; mode++) begin
      c.curve_mode = MODE_BITS'(mode);
      c.bounds_fix = 1'(mode);
      c.clip_limit = (mode == 3) ? SAMPLE_BITS'(-40000) : SAMPLE_BITS'(50000);
      load_cfg(c);
      send_edge_samples();
    end
    c.curve_mode = MODE_BITS'(7);
    load_cfg(c);
    send_sample(SAMPLE_BITS'(90000), 1'b1, 0);
  endtask

  // Extreme register settings: zero and full gains, most negative limit
  task automatic test_extreme_regs();
    cfg_t c;
    c = reset_cfg();
    c.curve_mode = MODE_LINEAR;
    c.gain_factor = '1;
    c.bounds_fix = 1'b0;
    c.clip_limit = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    load_cfg(c);
    send_sample(SAMPLE_BITS'(-300000), 1'b0, 0);
    send_sample(SAMPLE_BITS'(300000), 1'b1, 0);
    c.curve_mode = MODE_TANH;
    c.tanh_norm = '1;
    c.gain_factor = '0;
    c.adaptive_enable = 1'b1;
    c.adaptive_gain = '0;
    c.clip_limit = '0;
    load_cfg(c);
    send_sample(SAMPLE_BITS'(70000), 1'b0, 0);
  endtask

  // Random register sets, each followed by a burst of random samples
  task automatic test_random_streams();
    for (int phase = 0; phase < 14; phase++) begin
      load_cfg(random_cfg());
      for (int n = 0; n < 60; n++) send_sample(pick_sample(), 1'($urandom), pick_gap());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    fill_tanh_lut();
    shadow_cfg = reset_cfg();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_each_curve();
    test_extreme_regs();
    test_random_streams();

    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
